// ===== rtl/sbfe_pkg.sv =====
// ----------------------------------------------------------------------------
// SBUS frame encoder package
// Shared request types, register indexes, sequencer states and constants.
// ----------------------------------------------------------------------------
package sbfe_pkg;

  // Input request: a channel write or a one-millisecond tick
  typedef struct packed {
    logic        kind;
    logic [4:0]  channel_index;
    logic [15:0] channel_value;
    logic        end_of_update;
  } in_item_t;

  // Result request: one frame byte
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_item_t;

  // Request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_OUTPUT_ENABLE = 2'd0,
    CFG_FRAME_PERIOD  = 2'd1,
    CFG_STALE_TIMEOUT = 2'd2
  } cfg_idx_t;

  // Frame sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCALE_A,
    ST_SCALE_B,
    ST_LOAD,
    ST_BITS,
    ST_FLAGS,
    ST_END
  } state_t;

  // Packer control and status
  typedef struct packed {
    logic load;
    logic step;
  } pk_ctrl_t;

  typedef struct packed {
    logic       chan_last;
    logic       byte_last;
    logic       byte_empty;
    logic [7:0] byte_next;
  } pk_stat_t;

  // Frame constants
  localparam logic [7:0]  SBUS_START        = 8'h0F;
  localparam logic [7:0]  SBUS_END          = 8'h00;
  localparam logic [15:0] PWM_RESET         = 16'd1500;
  localparam logic [15:0] PWM_LOW           = 16'd1000;
  localparam logic [15:0] PWM_HIGH          = 16'd2000;
  localparam logic [10:0] SBUS_LOW          = 11'd172;
  localparam logic [15:0] DIGITAL_THRESHOLD = 16'd1024;
  localparam logic [15:0] PWM_IGNORE_LO     = 16'h0000;
  localparam logic [15:0] PWM_IGNORE_HI     = 16'hFFFF;
  localparam logic [9:0]  PERIOD_MIN        = 10'd5;
  localparam logic [9:0]  PERIOD_MAX        = 10'd1000;
  localparam logic [9:0]  PERIOD_RESET      = 10'd10;
  localparam logic [15:0] TIMEOUT_RESET     = 16'd500;
  localparam logic [15:0] MS_SAT            = 16'hFFFF;

  // Proportional channels in the frame and bits per packed value
  localparam int unsigned FRAME_CHANNELS = 16;
  localparam int unsigned SBUS_BITS      = 11;
  localparam int unsigned DIGITAL_CH0    = 16;
  localparam int unsigned DIGITAL_CH1    = 17;

  // floor(d * 1639 / 1000) == (d * SCALE_MUL) >> SCALE_SHIFT for d <= 1000
  localparam int unsigned SCALE_SHIFT = 22;
  localparam logic [22:0] SCALE_MUL   = 23'd6874465;

endpackage

// ===== rtl/sbfe_scale.sv =====
// ----------------------------------------------------------------------------
// SBUS channel scaler
// Clamps a PWM value to 1000..2000 and maps it to 172..1811, two stages.
// ----------------------------------------------------------------------------
module sbfe_scale (
  input  logic        clk,
  input  logic [15:0] pwm,
  output logic [10:0] sbus
);

  logic [9:0]  d_r;
  logic [9:0]  d_nxt;
  logic [32:0] prod_r;
  logic [32:0] prod_nxt;

  // Clamp and remove the offset
  always_comb begin
    if (pwm < sbfe_pkg::PWM_LOW) begin
      d_nxt = 10'd0;
    end else if (pwm > sbfe_pkg::PWM_HIGH) begin
      d_nxt = 10'(sbfe_pkg::PWM_HIGH - sbfe_pkg::PWM_LOW);
    end else begin
      d_nxt = 10'(pwm - sbfe_pkg::PWM_LOW);
    end
  end

  // Multiply by the reciprocal-scaled ratio
  assign prod_nxt = 33'(d_r) * 33'(sbfe_pkg::SCALE_MUL);

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    prod_r <= prod_nxt;
  end

  // Drop the fraction and add the SBUS floor
  assign sbus = prod_r[32:sbfe_pkg::SCALE_SHIFT] + sbfe_pkg::SBUS_LOW;

endmodule

// ===== rtl/sbfe_packer.sv =====
// ----------------------------------------------------------------------------
// SBUS bit packer
// Shifts 11-bit channel values LSB-first, one bit a cycle while stepped, into frame bytes.
// ----------------------------------------------------------------------------
module sbfe_packer (
  input  logic               clk,
  input  logic               rst_n,
  input  sbfe_pkg::pk_ctrl_t ctrl,
  input  logic [10:0]        load_val,
  output sbfe_pkg::pk_stat_t stat
);

  logic [10:0] val_r;
  logic [10:0] val_nxt;
  logic [3:0]  vcnt_r;
  logic [3:0]  vcnt_nxt;
  logic [7:0]  byte_r;
  logic [7:0]  byte_nxt;
  logic [2:0]  bcnt_r;
  logic [2:0]  bcnt_nxt;

  // Load a value or advance one bit
  always_comb begin
    val_nxt  = val_r;
    vcnt_nxt = vcnt_r;
    byte_nxt = byte_r;
    bcnt_nxt = bcnt_r;
    if (ctrl.load) begin
      val_nxt  = load_val;
      vcnt_nxt = 4'd0;
    end else if (ctrl.step) begin
      val_nxt  = {1'b0, val_r[10:1]};
      vcnt_nxt = vcnt_r + 4'd1;
      byte_nxt = {val_r[0], byte_r[7:1]};
      bcnt_nxt = bcnt_r + 3'd1;
    end
  end

  // Hold payload bits
  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    byte_r <= byte_nxt;
  end

  // Hold bit counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= 4'd0;
      bcnt_r <= 3'd0;
    end else begin
      vcnt_r <= vcnt_nxt;
      bcnt_r <= bcnt_nxt;
    end
  end

  assign stat.chan_last  = (vcnt_r == 4'(sbfe_pkg::SBUS_BITS - 1));
  assign stat.byte_last  = (bcnt_r == 3'd7);
  assign stat.byte_empty = (bcnt_r == 3'd0);
  assign stat.byte_next  = {val_r[0], byte_r[7:1]};

endmodule

// ===== rtl/sbus_frame_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// SBUS frame encoder unit
// Stores 18 PWM channels and emits 25-byte SBUS frames on period ticks.
// ----------------------------------------------------------------------------
// Use: the input channel (in_valid, in_stall, in_data) carries channel writes
// and one-millisecond ticks. A write gives no result. A tick that ends a frame
// period while output is enabled yields 25 result requests on (out_valid,
// out_stall, out_data), last_byte set on the end byte.
// The 16 proportional channels are scaled in a two-stage multiplier, then
// packed into bytes one bit per cycle, except while a full byte waits for the
// output register: each channel passes ST_SCALE_A, ST_SCALE_B and ST_LOAD,
// then shifts out its 11 bits, and in_stall stays high for the whole frame.
// Writes and ticks that give no frame are accepted every cycle while idle.
// The configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no frame is in progress.
// Reset restores all channels to 1500, clears the timers and sets the
// registers to disabled, 10 ms period and 500 ms timeout.
// A stalled receiver holds the output register; packing waits for it.
// ----------------------------------------------------------------------------
module sbus_frame_encoder_unit #(
  parameter int NUM_CHANNELS = 18
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sbfe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sbfe_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int IDXW = $clog2(NUM_CHANNELS);

  // Configuration
  logic        out_en_r;
  logic [9:0]  period_cfg_r;
  logic [15:0] timeout_r;

  // Channel and timer state
  logic [15:0] store_r [NUM_CHANNELS];
  logic [15:0] ms_since_r;
  logic [15:0] ms_since_nxt;
  logic        ever_r;
  logic        ever_nxt;
  logic [9:0]  pcount_r;
  logic [9:0]  pcount_nxt;

  // Sequencer
  sbfe_pkg::state_t state_r;
  sbfe_pkg::state_t state_nxt;
  logic [3:0]       ch_r;
  logic [3:0]       ch_nxt;

  // Output register
  logic                out_valid_r;
  sbfe_pkg::out_item_t out_r;
  logic                push;
  sbfe_pkg::out_item_t push_data;
  logic                out_free;

  // Datapath links
  sbfe_pkg::pk_ctrl_t pk_ctrl;
  sbfe_pkg::pk_stat_t pk_stat;
  logic [10:0]        sbus_val;

  logic        in_acc;
  logic        is_tick;
  logic        is_write;
  logic        wr_ok;
  logic [9:0]  period_eff;
  logic [10:0] pnext;
  logic        frame_due;
  logic        stale;
  logic [7:0]  flags;

  assign in_acc    = in_valid && !in_stall;
  assign is_tick   = in_acc && (in_data.kind == sbfe_pkg::KIND_TICK);
  assign is_write  = in_acc && (in_data.kind == sbfe_pkg::KIND_WRITE);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != sbfe_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_en_r     <= 1'b0;
      period_cfg_r <= sbfe_pkg::PERIOD_RESET;
      timeout_r    <= sbfe_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sbfe_pkg::cfg_idx_t'(cfg_index))
        sbfe_pkg::CFG_OUTPUT_ENABLE: out_en_r     <= cfg_data[0];
        sbfe_pkg::CFG_FRAME_PERIOD:  period_cfg_r <= cfg_data[9:0];
        sbfe_pkg::CFG_STALE_TIMEOUT: timeout_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Store a channel value unless out of range or a no-change code
  assign wr_ok = is_write
              && ({1'b0, in_data.channel_index} < 6'(NUM_CHANNELS))
              && (in_data.channel_value != sbfe_pkg::PWM_IGNORE_LO)
              && (in_data.channel_value != sbfe_pkg::PWM_IGNORE_HI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        store_r[i] <= sbfe_pkg::PWM_RESET;
      end
    end else if (wr_ok) begin
      store_r[in_data.channel_index[IDXW-1:0]] <= in_data.channel_value;
    end
  end

  // Clamp the period and test for elapse
  always_comb begin
    if (period_cfg_r < sbfe_pkg::PERIOD_MIN) begin
      period_eff = sbfe_pkg::PERIOD_MIN;
    end else if (period_cfg_r > sbfe_pkg::PERIOD_MAX) begin
      period_eff = sbfe_pkg::PERIOD_MAX;
    end else begin
      period_eff = period_cfg_r;
    end
  end

  assign pnext     = {1'b0, pcount_r} + 11'd1;
  assign frame_due = !(pnext < {1'b0, period_eff});

  // Advance staleness timer and period counter
  always_comb begin
    ms_since_nxt = ms_since_r;
    ever_nxt     = ever_r;
    pcount_nxt   = pcount_r;
    if (is_write && in_data.end_of_update) begin
      ms_since_nxt = 16'd0;
      ever_nxt     = 1'b1;
    end
    if (is_tick) begin
      if (ms_since_r != sbfe_pkg::MS_SAT) begin
        ms_since_nxt = ms_since_r + 16'd1;
      end
      pcount_nxt = frame_due ? 10'd0 : pnext[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_since_r <= 16'd0;
      ever_r     <= 1'b0;
      pcount_r   <= 10'd0;
    end else begin
      ms_since_r <= ms_since_nxt;
      ever_r     <= ever_nxt;
      pcount_r   <= pcount_nxt;
    end
  end

  // Flag byte from the digital channels and staleness
  assign stale = !ever_r || (ms_since_r > timeout_r);
  assign flags = {4'b0000, stale, stale,
                  store_r[sbfe_pkg::DIGITAL_CH1] > sbfe_pkg::DIGITAL_THRESHOLD,
                  store_r[sbfe_pkg::DIGITAL_CH0] > sbfe_pkg::DIGITAL_THRESHOLD};

  // Scale the current channel
  sbfe_scale u_scale (
    .clk  (clk),
    .pwm  (store_r[IDXW'(ch_r)]),
    .sbus (sbus_val)
  );

  // Pack scaled bits into bytes
  sbfe_packer u_packer (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (pk_ctrl),
    .load_val (sbus_val),
    .stat     (pk_stat)
  );

  // Sequence one frame
  always_comb begin
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    push           = 1'b0;
    push_data      = '{frame_byte: sbfe_pkg::SBUS_END, last_byte: 1'b0};
    pk_ctrl.load   = 1'b0;
    pk_ctrl.step   = 1'b0;
    unique case (state_r)
      sbfe_pkg::ST_IDLE: begin
        if (is_tick && frame_due && out_en_r) begin
          ch_nxt    = 4'd0;
          state_nxt = sbfe_pkg::ST_START;
        end
      end
      sbfe_pkg::ST_START: begin
        if (out_free) begin
          push      = 1'b1;
          push_data = '{frame_byte: sbfe_pkg::SBUS_START, last_byte: 1'b0};
          state_nxt = sbfe_pkg::ST_SCALE_A;
        end
      end
      sbfe_pkg::ST_SCALE_A: state_nxt = sbfe_pkg::ST_SCALE_B;
      sbfe_pkg::ST_SCALE_B: state_nxt = sbfe_pkg::ST_LOAD;
      sbfe_pkg::ST_LOAD: begin
        pk_ctrl.load = 1'b1;
        state_nxt    = sbfe_pkg::ST_BITS;
      end
      sbfe_pkg::ST_BITS: begin
        if (!pk_stat.byte_last || out_free) begin
          pk_ctrl.step = 1'b1;
          if (pk_stat.byte_last) begin
            push      = 1'b1;
            push_data = '{frame_byte: pk_stat.byte_next, last_byte: 1'b0};
          end
          if (pk_stat.chan_last) begin
            if (ch_r == 4'(sbfe_pkg::FRAME_CHANNELS - 1)) begin
              state_nxt = sbfe_pkg::ST_FLAGS;
            end else begin
              ch_nxt    = ch_r + 4'd1;
              state_nxt = sbfe_pkg::ST_SCALE_A;
            end
          end
        end
      end
      sbfe_pkg::ST_FLAGS: begin
        if (out_free) begin
          push      = 1'b1;
          push_data = '{frame_byte: flags, last_byte: 1'b0};
          state_nxt = sbfe_pkg::ST_END;
        end
      end
      sbfe_pkg::ST_END: begin
        if (out_free) begin
          push      = 1'b1;
          push_data = '{frame_byte: sbfe_pkg::SBUS_END, last_byte: 1'b1};
          state_nxt = sbfe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sbfe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbfe_pkg::ST_IDLE;
      ch_r    <= 4'd0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  // Output register: load on push, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r <= push_data;
    end
  end

  // A frame starts only from an accepted tick
  a_start_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbfe_pkg::ST_START && $past(state_r) != sbfe_pkg::ST_START)
      |-> $past(is_tick))
    else $error("frame started without a tick");

  // A completed byte waits while the output register is held
  a_hold_full_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbfe_pkg::ST_BITS && pk_stat.byte_last && !out_free)
      |=> (state_r == sbfe_pkg::ST_BITS && pk_stat.byte_last))
    else $error("packer advanced past a full byte");

  // Channel bits end on a byte boundary
  a_flags_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbfe_pkg::ST_FLAGS) |-> pk_stat.byte_empty)
    else $error("flag byte reached with partial packed byte");

  // The end byte carries zero; only idle or a waiting start byte follows it
  a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last_byte)
      |-> (out_r.frame_byte == sbfe_pkg::SBUS_END
           && (state_r == sbfe_pkg::ST_IDLE || state_r == sbfe_pkg::ST_START)))
    else $error("end byte out of place");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SBUS frame encoder unit testbench
// Sends channel writes and millisecond ticks with random gaps and random
// output stalls. Predicts every frame byte from a mirror of the channel store,
// timers and registers, then checks the byte stream in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CHANNELS     = 18;
  localparam int unsigned SBUS_TOP     = 1811;
  localparam int unsigned SETTLE       = 20;
  localparam int unsigned HANG_LIMIT   = 5000;
  localparam int unsigned RANDOM_ITEMS = 23;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  sbfe_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sbfe_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = sbfe_pkg::CFG_OUTPUT_ENABLE;
  logic [15:0]         cfg_data  = '0;

  // Mirror of the encoder state and registers
  logic [15:0] pwm_mirror [CHANNELS];
  logic [15:0] ms_idle;
  logic        seen_update;
  logic [9:0]  period_cnt;
  logic        enable_reg;
  logic [9:0]  period_reg;
  logic [15:0] timeout_reg;

  sbfe_pkg::out_item_t frame_bytes_due [$];
  sbfe_pkg::in_item_t  stim_queue [$];
  sbfe_pkg::out_item_t byte_want;

  int unsigned items_sent  = 0;
  int unsigned items_taken = 0;
  int unsigned errors      = 0;
  int unsigned hang_cnt    = 0;
  int unsigned in_gap      = 0;
  int unsigned in_run      = 0;
  int unsigned stall_left  = 0;
  logic        in_fire     = 1'b0;
  logic        calm        = 1'b0;

  sbus_frame_encoder_unit #(
    .NUM_CHANNELS(CHANNELS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp to 1000..2000 us and map linearly onto 172..1811
  function automatic logic [10:0] sbus_level(logic [15:0] pwm);
    int unsigned p;
    int unsigned s;
    p = 32'(pwm);
    if (p < 32'(sbfe_pkg::PWM_LOW)) p = 32'(sbfe_pkg::PWM_LOW);
    if (p > 32'(sbfe_pkg::PWM_HIGH)) p = 32'(sbfe_pkg::PWM_HIGH);
    s = 32'(sbfe_pkg::SBUS_LOW) + (p - 32'(sbfe_pkg::PWM_LOW))
        * (SBUS_TOP - 32'(sbfe_pkg::SBUS_LOW))
        / 32'(sbfe_pkg::PWM_HIGH - sbfe_pkg::PWM_LOW);
    return s[10:0];
  endfunction

  function automatic sbfe_pkg::out_item_t frame_entry(logic [7:0] b, logic last);
    sbfe_pkg::out_item_t e;
    e.frame_byte = b;
    e.last_byte  = last;
    return e;
  endfunction

  // Build the 25 bytes of one frame and queue them
  task automatic push_frame(logic stale);
    logic [175:0] packed_bits;
    logic [7:0]   flags;
    int           i;
    packed_bits = '0;
    for (i = 0; i < sbfe_pkg::FRAME_CHANNELS; i++) begin
      packed_bits[i*sbfe_pkg::SBUS_BITS +: sbfe_pkg::SBUS_BITS] = sbus_level(pwm_mirror[i]);
    end
    flags = '0;
    if (pwm_mirror[sbfe_pkg::DIGITAL_CH0] > sbfe_pkg::DIGITAL_THRESHOLD) flags[0] = 1'b1;
    if (pwm_mirror[sbfe_pkg::DIGITAL_CH1] > sbfe_pkg::DIGITAL_THRESHOLD) flags[1] = 1'b1;
    if (stale) flags[3:2] = 2'b11;
    frame_bytes_due.push_back(frame_entry(sbfe_pkg::SBUS_START, 1'b0));
    for (i = 0; i < 22; i++) begin
      frame_bytes_due.push_back(frame_entry(packed_bits[i*8 +: 8], 1'b0));
    end
    frame_bytes_due.push_back(frame_entry(flags, 1'b0));
    frame_bytes_due.push_back(frame_entry(sbfe_pkg::SBUS_END, 1'b1));
  endtask

  // Advance the mirror by one accepted request
  task automatic encoder_step(sbfe_pkg::in_item_t it);
    int unsigned eff;
    int unsigned nxt;
    if (it.kind == sbfe_pkg::KIND_WRITE) begin
      if (32'(it.channel_index) < CHANNELS && it.channel_value != sbfe_pkg::PWM_IGNORE_LO &&
          it.channel_value != sbfe_pkg::PWM_IGNORE_HI)
        pwm_mirror[it.channel_index] = it.channel_value;
      if (it.end_of_update) begin
        ms_idle     = '0;
        seen_update = 1'b1;
      end
    end else begin
      if (ms_idle != sbfe_pkg::MS_SAT) ms_idle = ms_idle + 16'd1;
      eff = 32'(period_reg);
      if (eff < 32'(sbfe_pkg::PERIOD_MIN)) eff = 32'(sbfe_pkg::PERIOD_MIN);
      if (eff > 32'(sbfe_pkg::PERIOD_MAX)) eff = 32'(sbfe_pkg::PERIOD_MAX);
      nxt = 32'(period_cnt) + 1;
      if (nxt < eff) begin
        period_cnt = nxt[9:0];
      end else begin
        period_cnt = '0;
        if (enable_reg) push_frame(!seen_update || ms_idle > timeout_reg);
      end
    end
  endtask

  // Predict on accepted requests, check bytes, watch for a hang
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      encoder_step(in_data);
      items_taken++;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (sbfe_pkg::cfg_idx_t'(cfg_index))
        sbfe_pkg::CFG_OUTPUT_ENABLE: enable_reg  = cfg_data[0];
        sbfe_pkg::CFG_FRAME_PERIOD:  period_reg  = cfg_data[9:0];
        sbfe_pkg::CFG_STALE_TIMEOUT: timeout_reg = cfg_data;
        default: ;
      endcase
    end
    if (rst_n && out_valid && !out_stall) begin
      if (frame_bytes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte, expected none, got %h last %b",
                 $time, out_data.frame_byte, out_data.last_byte);
      end else begin
        byte_want = frame_bytes_due.pop_front();
        if (out_data.frame_byte !== byte_want.frame_byte) begin
          errors++;
          $display("%0t: frame_byte mismatch, expected %h, got %h",
                   $time, byte_want.frame_byte, out_data.frame_byte);
        end
        if (out_data.last_byte !== byte_want.last_byte) begin
          errors++;
          $display("%0t: last_byte mismatch, expected %b, got %b",
                   $time, byte_want.last_byte, out_data.last_byte);
        end
      end
    end
    in_fire <= rst_n && in_valid && !in_stall;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      hang_cnt = 0;
    else
      hang_cnt++;
    if (hang_cnt >= HANG_LIMIT) begin
      $display("FAIL sbus_frame_encoder_unit");
      $finish;
    end
  end

  // Feed requests from the pending queue, with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // hold the stalled request
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (stim_queue.size() == 0) begin
      in_valid <= 1'b0;
    end else if (!calm && in_run == 0 && $urandom_range(0, 3) == 0) begin
      in_gap = $urandom_range(0, 13);
      in_valid <= 1'b0;
    end else begin
      in_data  <= stim_queue.pop_front();
      in_valid <= 1'b1;
      if (in_run > 0) in_run--;
      else if ($urandom_range(0, 15) == 0) in_run = $urandom_range(10, 40);
    end
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      case ($urandom_range(0, 5))
        0: begin
          out_stall  <= 1'b1;
          stall_left = $urandom_range(0, 13);
        end
        1: begin
          out_stall  <= 1'b0;
          stall_left = $urandom_range(10, 40);
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  function automatic sbfe_pkg::in_item_t tick_item();
    sbfe_pkg::in_item_t it;
    it = '0;
    it.kind = sbfe_pkg::KIND_TICK;
    it.channel_index = 5'($urandom_range(0, 31));
    it.channel_value = 16'($urandom_range(0, 65535));
    it.end_of_update = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic sbfe_pkg::in_item_t write_item(logic [4:0] idx, logic [15:0] val,
                                                    logic eou);
    sbfe_pkg::in_item_t it;
    it.kind          = sbfe_pkg::KIND_WRITE;
    it.channel_index = idx;
    it.channel_value = val;
    it.end_of_update = eou;
    return it;
  endfunction

  task automatic queue_item(sbfe_pkg::in_item_t it);
    stim_queue.push_back(it);
    items_sent++;
  endtask

  task automatic write_reg(sbfe_pkg::cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic en, logic [9:0] per, logic [15:0] tmo);
    write_reg(sbfe_pkg::CFG_OUTPUT_ENABLE, {15'd0, en});
    write_reg(sbfe_pkg::CFG_FRAME_PERIOD, {6'd0, per});
    write_reg(sbfe_pkg::CFG_STALE_TIMEOUT, tmo);
  endtask

  // Wait until every request is taken and every byte has come back
  task automatic drain();
    while (items_taken != items_sent || frame_bytes_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Mostly updates and ticks, some noise writes
  task automatic random_items(int unsigned n);
    int unsigned done;
    int unsigned burst;
    int unsigned k;
    logic [15:0] val;
    done = 0;
    while (done < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          queue_item(tick_item());
          done++;
        end
        5, 6, 7, 8: begin
          burst = $urandom_range(1, 4);
          for (k = 0; k < burst; k++) begin
            case ($urandom_range(0, 7))
              0: val = sbfe_pkg::PWM_LOW;
              1: val = sbfe_pkg::PWM_HIGH;
              2: val = 16'($urandom_range(1, 999));
              3: val = 16'($urandom_range(2001, 65534));
              default: val = 16'($urandom_range(900, 2100));
            endcase
            queue_item(write_item(5'($urandom_range(0, CHANNELS - 1)), val,
                                  k == burst - 1 && $urandom_range(0, 7) != 0));
          end
          done += burst;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: val = sbfe_pkg::PWM_IGNORE_LO;
            1: val = sbfe_pkg::PWM_IGNORE_HI;
            default: val = 16'($urandom_range(0, 65535));
          endcase
          queue_item(write_item(5'($urandom_range(0, 31)), val,
                                1'($urandom_range(0, 1))));
          done++;
        end
      endcase
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < CHANNELS; i++) pwm_mirror[i] = sbfe_pkg::PWM_RESET;
    ms_idle     = '0;
    seen_update = 1'b0;
    period_cnt  = '0;
    enable_reg  = 1'b0;
    period_reg  = sbfe_pkg::PERIOD_RESET;
    timeout_reg = sbfe_pkg::TIMEOUT_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Frame from reset values: never updated, so marked stale
    set_regs(1'b1, 10'd0, 16'hFFFF);
    repeat (5) queue_item(tick_item());
    // Ignored values, end mark on a bad index, clamp extremes, digital thresholds
    queue_item(write_item(5'd0, sbfe_pkg::PWM_IGNORE_LO, 1'b0));
    queue_item(write_item(5'd1, sbfe_pkg::PWM_IGNORE_HI, 1'b0));
    queue_item(write_item(5'd31, 16'd1700, 1'b1));
    queue_item(write_item(5'd2, 16'd1, 1'b0));
    queue_item(write_item(5'd3, 16'hFFFE, 1'b0));
    queue_item(write_item(5'd4, sbfe_pkg::PWM_LOW, 1'b0));
    queue_item(write_item(5'd5, sbfe_pkg::PWM_HIGH, 1'b0));
    queue_item(write_item(5'd16, 16'd1025, 1'b0));
    queue_item(write_item(5'd17, 16'd1024, 1'b0));
    repeat (5) queue_item(tick_item());
    drain();
    // Output off: the due frame is dropped
    set_regs(1'b0, 10'd5, 16'd1);
    repeat (5) queue_item(tick_item());
    drain();

    // Random phases across several register settings
    set_regs(1'b1, 10'd5, 16'd3);
    random_items(RANDOM_ITEMS);
    drain();
    set_regs(1'b1, 10'($urandom_range(0, 12)), 16'd0);
    random_items(RANDOM_ITEMS);
    drain();
    set_regs(1'b0, 10'd8, 16'd40);
    random_items(RANDOM_ITEMS);
    drain();
    repeat (2) begin
      set_regs(1'b1, 10'($urandom_range(0, 12)), 16'($urandom_range(1, 30)));
      random_items(RANDOM_ITEMS);
      drain();
    end

    // Last phase without gaps or stalls
    calm = 1'b1;
    set_regs(1'b1, 10'd6, 16'd10);
    random_items(RANDOM_ITEMS);
    drain();

    if (errors == 0 && frame_bytes_due.size() == 0)
      $display("PASS sbus_frame_encoder_unit");
    else
      $display("FAIL sbus_frame_encoder_unit");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sbfe_pkg.sv
rtl/sbfe_scale.sv
rtl/sbfe_packer.sv
rtl/sbus_frame_encoder_unit.sv
dv/testbench.sv
